@@ rtl/core/pfp_pkg.sv @@
package pfp_pkg;

    localparam int FRAME_BYTES = 32;
    localparam int SUM_BYTES   = 30;
    localparam int DATA_START  = 4;
    localparam int DATA_WORDS  = 12;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam int IDX_W       = 4;

    localparam logic [POS_W-1:0] POS_SECOND    = POS_W'(1);
    localparam logic [POS_W-1:0] POS_DATA_LO   = POS_W'(DATA_START);
    localparam logic [POS_W-1:0] POS_DATA_HI   = POS_W'(DATA_START + 2 * DATA_WORDS - 1);
    localparam logic [POS_W-1:0] POS_CHK_HI    = POS_W'(SUM_BYTES);
    localparam logic [POS_W-1:0] POS_LAST      = POS_W'(FRAME_BYTES - 1);
    localparam logic [IDX_W-1:0] LAST_INDEX    = IDX_W'(DATA_WORDS - 1);

    // register map, one word per register
    localparam logic REG_FIRST_START  = 1'b0;
    localparam logic REG_SECOND_START = 1'b1;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] word_t;
    typedef word_t [DATA_WORDS-1:0] frame_words_t;

    typedef struct packed {
        logic         valid;
        frame_words_t words;
    } frame_push_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

@@ rtl/core/particulate_frame_parser.sv @@
// particulate sensor frame parser. one received byte is taken per cycle: the
// block hunts for the first start byte, demands the second start byte right
// after it (a wrong one drops sync and is not retried as an opener), then
// collects a 32-byte frame while summing bytes 0 to 29. when byte 31 arrives
// the sum is checked against the big-endian word in bytes 30-31 and the stored
// start bytes against the current registers; a good frame queues its twelve
// big-endian data words (bytes 4-27), which leave one word per cycle unless
// stalled, as index/value pairs with last_field set on index 11. bad frames
// emit nothing. input rate is one byte per cycle, set by the combinational
// sum and byte capture; the output burst is 12 words per frame, and a two-frame
// queue between collector and emitter holds off only the closing byte of a
// frame when both queued frames are still waiting to be sent.
// registers: 0x0 first start byte (reset 0x42), 0x4 second start byte
// (reset 0x4d), 8 bits each in a 32-bit word
module particulate_frame_parser (
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // byte input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    // field output
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  field_index,
    output logic [15:0] field_value,
    output logic        last_field
);
    import pfp_pkg::*;

    byte_t         first_start_reg;
    byte_t         second_start_reg;
    logic          cfg_write;
    frame_push_t   push;
    queue_status_t q_status;
    frame_words_t  head;
    logic          pop;

    // word offset picks the register, low address bits are not decoded
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_start_reg  <= 8'h42;
            second_start_reg <= 8'h4d;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_FIRST_START:  first_start_reg  <= pwdata[7:0];
                REG_SECOND_START: second_start_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_FIRST_START:  prdata = {24'h0, first_start_reg};
            REG_SECOND_START: prdata = {24'h0, second_start_reg};
            default:          prdata = '0;
        endcase
    end

    // collector: sync hunt, checksum and word capture
    pfp_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .rx_byte           (rx_byte),
        .first_start_byte  (first_start_reg),
        .second_start_byte (second_start_reg),
        .q_status          (q_status),
        .push              (push)
    );

    // good frames waiting to be sent
    pfp_frame_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .status (q_status),
        .head   (head)
    );

    // emitter: walks the head frame one word per cycle, unless out_ready stalls it, into the output register
    pfp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .field_index (field_index),
        .field_value (field_value),
        .last_field  (last_field)
    );

endmodule

@@ rtl/core/pfp_front.sv @@
module pfp_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            rx_byte,
    input  logic [7:0]            first_start_byte,
    input  logic [7:0]            second_start_byte,
    input  pfp_pkg::queue_status_t q_status,
    output pfp_pkg::frame_push_t   push
);
    import pfp_pkg::*;

    logic             locked_reg, locked_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    word_t            sum_reg, sum_next;
    byte_t            byte0_reg, byte0_next;
    byte_t            byte1_reg, byte1_next;
    byte_t            byte30_reg, byte30_next;
    frame_words_t     words_reg, words_next;

    logic             accept;
    logic [POS_W-1:0] word_off;
    logic [IDX_W-1:0] widx;
    logic             good;

    // only the closing byte of a frame needs room in the queue
    assign in_ready = !(locked_reg && pos_reg == POS_LAST && q_status.full);
    assign accept   = in_valid && in_ready;

    assign word_off = pos_reg - POS_DATA_LO;
    assign widx     = IDX_W'(word_off >> 1);
    assign good     = byte0_reg == first_start_byte && byte1_reg == second_start_byte
                      && sum_reg == {byte30_reg, rx_byte};

    always_comb
    begin
        locked_next = locked_reg;
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        byte0_next  = byte0_reg;
        byte1_next  = byte1_reg;
        byte30_next = byte30_reg;
        words_next  = words_reg;
        push.valid  = 1'b0;
        push.words  = words_reg;
        if (accept)
        begin
            if (!locked_reg)
            begin
                if (rx_byte == first_start_byte)
                begin
                    byte0_next  = rx_byte;
                    sum_next    = {8'h00, rx_byte};
                    locked_next = 1'b1;
                    pos_next    = POS_SECOND;
                end
            end
            else if (pos_reg <= POS_SECOND)
            begin
                if (rx_byte == second_start_byte)
                begin
                    byte1_next = rx_byte;
                    sum_next   = sum_reg + {8'h00, rx_byte};
                    pos_next   = POS_SECOND + POS_W'(1);
                end
                else
                begin
                    locked_next = 1'b0;
                    pos_next    = '0;
                end
            end
            else
            begin
                if (pos_reg >= POS_DATA_LO && pos_reg <= POS_DATA_HI)
                begin
                    if (pos_reg[0])
                        words_next[widx][7:0] = rx_byte;
                    else
                        words_next[widx][15:8] = rx_byte;
                end
                if (pos_reg == POS_CHK_HI)
                    byte30_next = rx_byte;
                if (pos_reg < POS_CHK_HI)
                    sum_next = sum_reg + {8'h00, rx_byte};
                if (pos_reg != POS_LAST)
                    pos_next = pos_reg + POS_W'(1);
                else
                begin
                    locked_next = 1'b0;
                    pos_next    = '0;
                    push.valid  = good;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            locked_reg <= 1'b0;
            pos_reg    <= '0;
            sum_reg    <= '0;
        end
        else
        begin
            locked_reg <= locked_next;
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte0_reg  <= byte0_next;
        byte1_reg  <= byte1_next;
        byte30_reg <= byte30_next;
        words_reg  <= words_next;
    end

endmodule

@@ rtl/core/pfp_frame_queue.sv @@
module pfp_frame_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pfp_pkg::frame_push_t   push,
    input  logic                   pop,
    output pfp_pkg::queue_status_t status,
    output pfp_pkg::frame_words_t  head
);
    import pfp_pkg::*;

    frame_words_t entry_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;

    assign status.empty = count_reg == 2'd0;
    assign status.full  = count_reg == 2'd2;
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push.valid;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push.valid} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            entry_reg[wr_ptr_reg] <= push.words;
    end

endmodule

@@ rtl/core/pfp_back.sv @@
module pfp_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pfp_pkg::queue_status_t q_status,
    input  pfp_pkg::frame_words_t  head,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [3:0]             field_index,
    output logic [15:0]            field_value,
    output logic                   last_field
);
    import pfp_pkg::*;

    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] index_reg;
    word_t            value_reg;
    logic             last_reg;
    logic             load;

    assign load = !q_status.empty && (!out_valid_reg || out_ready);
    assign pop  = load && cnt_reg == LAST_INDEX;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        cnt_next       = cnt_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            cnt_next       = (cnt_reg == LAST_INDEX) ? '0 : cnt_reg + IDX_W'(1);
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            index_reg <= cnt_reg;
            value_reg <= head[cnt_reg];
            last_reg  <= cnt_reg == LAST_INDEX;
        end
    end

    assign out_valid   = out_valid_reg;
    assign field_index = index_reg;
    assign field_value = value_reg;
    assign last_field  = last_reg;

endmodule
